// ----- hw/rtl/akc_pkg.sv -----
// Package: types and constants for the aged key cache replacement unit.
`default_nettype none
package akc_pkg;

    localparam int ENTRIES_DEF = 8;
    localparam int LIM_W       = 10;
    localparam int AGE_W       = 11;
    localparam int KEY_W       = 32;
    localparam int SIZE_W      = 31;

    localparam logic [LIM_W-1:0] AGE_LIMIT_RST = 10'd1000;
    localparam logic [AGE_W-1:0] AGE_MAX       = 11'd2047;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_FREE   = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [KEY_W-1:0] key;
        logic [SIZE_W-1:0]       item_size;
        logic [2:0]              slot;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic [2:0]              entry_index;
        logic [SIZE_W-1:0]       stored_size;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [AGE_W-1:0]  age;
    } t_ent;

endpackage
`default_nettype wire

// ----- hw/rtl/aged_key_cache_replacement_unit.sv -----
// Aged key cache replacement unit: small fully associative keyed table with age-based replacement.
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one request word:
// lookup, insert, free slot or clear all. Output channel (o_out_valid /
// i_out_ready / o_out_word) returns exactly one response word per request.
// Lookup and insert walk the entry memory one entry per cycle through a
// single read port and a single compare/age unit, then enter the done
// state, which loads the response. Free slot and clear all go from accept
// straight to the done state. The next request is accepted once the response
// has been loaded into the output register, so a stalled receiver holds at
// most one response plus one request in progress; a request that finishes
// while the output register is still full waits until it drains.
// Age limit is written through i_cfg_wr_en / i_cfg_wr_data. The user must write it
// only while the unit is idle; the block itself does not enforce this.
// Reset (synchronous, active low) frees every entry and sets the age limit
// to 1000. Key, size and age storage is not cleared; per-entry valid flops
// gate every read, so the unit is ready in the first cycle after reset.
`default_nettype none
module aged_key_cache_replacement_unit #(
    parameter int ENTRIES = akc_pkg::ENTRIES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [akc_pkg::LIM_W-1:0]   i_cfg_wr_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire akc_pkg::t_req               i_in_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output akc_pkg::t_rsp                    o_out_word
);
    import akc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [LIM_W-1:0]      r_limit;
    logic [ENTRIES-1:0]    r_valid, n_valid;
    t_req                  r_req, n_req;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_ev_idx, n_ev_idx;
    logic                  r_hit, n_hit;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [SIZE_W-1:0]     r_size, n_size;
    logic                  r_have_free, n_have_free;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic [IDX_W-1:0]      r_old_idx, n_old_idx;
    logic [AGE_W-1:0]      r_best, n_best;
    logic [KEY_W-1:0]      r_best_key, n_best_key;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out, n_out;

    t_ent                  mem [ENTRIES];
    t_ent                  r_rd_data;
    logic [IDX_W-1:0]      rd_addr;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    t_ent                  mem_wdata;

    logic                  in_acc;
    logic                  ev_v;
    logic [AGE_W-1:0]      ev_age;
    logic [IDX_W-1:0]      chosen;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign chosen      = r_have_free ? r_free_idx : r_old_idx;

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_req       = r_req;
        n_cnt       = r_cnt;
        n_ev_idx    = r_ev_idx;
        n_hit       = r_hit;
        n_idx       = r_idx;
        n_size      = r_size;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_old_idx   = r_old_idx;
        n_best      = r_best;
        n_best_key  = r_best_key;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_ev_idx;
        mem_wdata   = r_rd_data;
        ev_v        = 1'b0;
        ev_age      = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req       = i_in_word;
                    n_cnt       = '0;
                    n_hit       = 1'b0;
                    n_idx       = '0;
                    n_size      = '0;
                    n_have_free = 1'b0;
                    n_free_idx  = '0;
                    n_old_idx   = '0;
                    n_best      = '0;
                    n_best_key  = '0;
                    unique case (t_func'(i_in_word.func))
                        FN_LOOKUP, FN_INSERT: begin
                            n_state = S_SCAN;
                        end
                        FN_FREE: begin
                            if (32'(i_in_word.slot) < 32'(ENTRIES)) begin
                                n_valid[IDX_W'(i_in_word.slot)] = 1'b0;
                            end
                            n_state = S_DONE;
                        end
                        FN_CLEAR: begin
                            n_valid = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_cnt < CNT_W'(ENTRIES)) begin
                    rd_addr = r_cnt[IDX_W-1:0];
                end
                n_ev_idx = rd_addr;
                if (r_cnt != '0) begin
                    ev_v = r_valid[r_ev_idx];
                    if (t_func'(r_req.func) == FN_LOOKUP) begin
                        if (ev_v && (r_rd_data.key == r_req.key) && !r_hit) begin
                            n_hit  = 1'b1;
                            n_idx  = r_ev_idx;
                            n_size = r_rd_data.size;
                        end
                    end else begin
                        // age guard: stale entries are freed, not evicted
                        if (ev_v && (r_rd_data.age > {1'b0, r_limit})) begin
                            n_valid[r_ev_idx] = 1'b0;
                            ev_v = 1'b0;
                        end
                        if (!ev_v) begin
                            if (!r_have_free) begin
                                n_have_free = 1'b1;
                                n_free_idx  = r_ev_idx;
                            end
                        end else begin
                            ev_age = (r_rd_data.age == AGE_MAX) ? AGE_MAX
                                                                : r_rd_data.age + 1'b1;
                            mem_we        = 1'b1;
                            mem_wdata.age = ev_age;
                            if (ev_age > r_best) begin
                                n_best     = ev_age;
                                n_old_idx  = r_ev_idx;
                                n_best_key = r_rd_data.key;
                            end
                        end
                    end
                end
                if (r_cnt == CNT_W'(ENTRIES)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (t_func'(r_req.func) == FN_INSERT) begin
                    mem_we          = 1'b1;
                    mem_waddr       = chosen;
                    mem_wdata.key   = r_req.key;
                    mem_wdata.size  = r_req.item_size;
                    mem_wdata.age   = '0;
                    n_valid[chosen] = 1'b1;
                end
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.hit         = r_hit;
                    n_out.entry_index = 3'(r_idx);
                    n_out.stored_size = r_size;
                    n_out.evicted     = 1'b0;
                    n_out.evicted_key = '0;
                    if (t_func'(r_req.func) == FN_INSERT) begin
                        n_out.entry_index = 3'(chosen);
                        n_out.evicted     = !r_have_free;
                        n_out.evicted_key = r_have_free ? '0 : r_best_key;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= AGE_LIMIT_RST;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_ev_idx    <= n_ev_idx;
        r_hit       <= n_hit;
        r_idx       <= n_idx;
        r_size      <= n_size;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_old_idx   <= n_old_idx;
        r_best      <= n_best;
        r_best_key  <= n_best_key;
        r_out       <= n_out;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request accepted while previous one in progress");

    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.hit && o_out_word.evicted))
        else $error("response flags both hit and eviction");

    a_miss_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.hit) |-> (o_out_word.stored_size == '0))
        else $error("size reported without a hit");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ENTRIES))
        else $error("scan counter out of range");

endmodule
`default_nettype wire
